// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, byte codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // error codes carried on a string-end result
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_CTRL = 3'd1;
  localparam logic [2:0] ERR_ESC  = 3'd2;
  localparam logic [2:0] ERR_HEX  = 3'd3;
  localparam logic [2:0] ERR_SURR = 3'd4;

  // input characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // decoded values of the single-letter escapes
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // code point limits
  localparam logic [20:0] CP_MAX_1B   = 21'h00007F;
  localparam logic [20:0] CP_MAX_2B   = 21'h0007FF;
  localparam logic [20:0] CP_MAX_3B   = 21'h00FFFF;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR_LO  = 16'hD800;
  localparam logic [15:0] HI_SURR_HI  = 16'hDBFF;

  localparam int MAX_RESULTS = 4;

  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_WANT_BS = 6'b001000,
    MODE_WANT_U  = 6'b010000,
    MODE_HEX2    = 6'b100000
  } jsu_mode_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;   // bytes[0] leaves first
    logic [2:0]                  cnt;     // number of results, 0..4
    logic                        has;     // data results (else one end result)
    logic                        fin;     // string end
    logic [2:0]                  err;
    logic                        last_en; // mark the final result
  } jsu_bundle_t;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic jsu_bundle_t byte_bundle(input logic [7:0] b);
    jsu_bundle_t r;
    r = '0;
    r.bytes[0] = b;
    r.cnt      = 3'd1;
    r.has      = 1'b1;
    r.last_en  = 1'b1;
    return r;
  endfunction

  function automatic jsu_bundle_t end_bundle(input logic [2:0] err, input logic last_en);
    jsu_bundle_t r;
    r = '0;
    r.cnt     = 3'd1;
    r.fin     = 1'b1;
    r.err     = err;
    r.last_en = last_en;
    return r;
  endfunction

  function automatic jsu_bundle_t utf8_encode(input logic [20:0] cp);
    jsu_bundle_t r;
    r = '0;
    r.has     = 1'b1;
    r.last_en = 1'b1;
    if (cp <= CP_MAX_1B) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 3'd1;
    end else if (cp <= CP_MAX_2B) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp <= CP_MAX_3B) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state machine: turns one raw byte into its bundle of results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte,
  input  wire logic        accept,
  output jsu_bundle_t      bundle
);

  jsu_mode_t   mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] hex_acc_r, hex_acc_nxt;
  logic [9:0]  hs_bits_r, hs_bits_nxt;

  logic [4:0]  hv;
  logic [15:0] acc_shift;
  logic [20:0] cp_pair;

  assign hv        = hex_value(in_byte);
  assign acc_shift = {hex_acc_r[11:0], hv[3:0]};
  assign cp_pair   = CP_SUPP_BASE + {1'b0, hs_bits_r, acc_shift[9:0]};

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    hs_bits_nxt = hs_bits_r;
    bundle      = '0;
    case (mode_r)
      MODE_PLAIN: begin
        if (in_byte == CH_NUL || in_byte inside {[CH_BEL:CH_CR]}) begin
          bundle = end_bundle(ERR_CTRL, 1'b0);
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
          hs_bits_nxt = '0;
        end else if (in_byte == CH_QUOTE) begin
          bundle = end_bundle(ERR_NONE, 1'b1);
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
          hs_bits_nxt = '0;
        end else if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          bundle = byte_bundle(in_byte);
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: bundle = byte_bundle(in_byte);
          CH_N: bundle = byte_bundle(BYTE_LF);
          CH_B: bundle = byte_bundle(BYTE_BS);
          CH_F: bundle = byte_bundle(BYTE_FF);
          CH_R: bundle = byte_bundle(BYTE_CR);
          CH_T: bundle = byte_bundle(BYTE_TAB);
          CH_U: begin
            mode_nxt    = MODE_HEX1;
            hex_cnt_nxt = '0;
            hex_acc_nxt = '0;
          end
          default: begin
            bundle = end_bundle(ERR_ESC, 1'b0);
            hex_cnt_nxt = '0;
            hex_acc_nxt = '0;
            hs_bits_nxt = '0;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hv[4]) begin
          bundle = end_bundle(ERR_HEX, 1'b0);
          mode_nxt    = MODE_PLAIN;
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
          hs_bits_nxt = '0;
        end else if (hex_cnt_r != 2'd3) begin
          hex_cnt_nxt = hex_cnt_r + 2'd1;
          hex_acc_nxt = acc_shift;
        end else if (mode_r == MODE_HEX1 &&
                     acc_shift >= HI_SURR_LO && acc_shift <= HI_SURR_HI) begin
          // high surrogate: park its payload and wait for the second unit
          hs_bits_nxt = acc_shift[9:0];
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
          mode_nxt    = MODE_WANT_BS;
        end else begin
          bundle = (mode_r == MODE_HEX1) ? utf8_encode({5'b0, acc_shift})
                                         : utf8_encode(cp_pair);
          mode_nxt    = MODE_PLAIN;
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
          hs_bits_nxt = '0;
        end
      end
      MODE_WANT_BS, MODE_WANT_U: begin
        if ((mode_r == MODE_WANT_BS && in_byte != CH_BSLASH) ||
            (mode_r == MODE_WANT_U && in_byte != CH_U)) begin
          bundle = end_bundle(ERR_SURR, 1'b0);
          mode_nxt    = MODE_PLAIN;
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
          hs_bits_nxt = '0;
        end else if (mode_r == MODE_WANT_BS) begin
          mode_nxt = MODE_WANT_U;
        end else begin
          mode_nxt    = MODE_HEX2;
          hex_cnt_nxt = '0;
          hex_acc_nxt = '0;
        end
      end
      default: begin
        mode_nxt    = MODE_PLAIN;
        hex_cnt_nxt = '0;
        hex_acc_nxt = '0;
        hs_bits_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PLAIN;
      hex_cnt_r <= '0;
      hex_acc_r <= '0;
      hs_bits_r <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_acc_r <= hex_acc_nxt;
      hs_bits_r <= hs_bits_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one byte's bundle and hands its results out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_emit import jsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire jsu_bundle_t bundle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_string_end,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);

  logic [MAX_RESULTS-1:0][7:0] bytes_r;
  logic [2:0]                  cnt_r;
  logic                        has_r;
  logic                        fin_r;
  logic [2:0]                  err_r;
  logic                        last_en_r;
  logic                        load;
  logic                        out_fire;

  assign out_valid = (cnt_r != 3'd0);
  assign out_fire  = out_valid && out_ready;
  // take a new transaction when empty or while the last pending result leaves
  assign in_ready  = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);
  assign load      = in_valid && in_ready;

  assign out_byte        = bytes_r[0];
  assign out_has_byte    = has_r;
  assign out_string_end  = fin_r;
  assign out_error_code  = err_r;
  assign out_last_of_run = last_en_r && (cnt_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= bundle.cnt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r   <= bundle.bytes;
      has_r     <= bundle.has;
      fin_r     <= bundle.fin;
      err_r     <= bundle.err;
      last_en_r <= bundle.last_en;
    end else if (out_fire) begin
      bytes_r <= bytes_r >> 8;
    end
  end

endmodule

`default_nettype wire

// File: hdl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw byte of the string body per transaction, starting after
//           the opening quote.
//   out_* : decoded UTF-8 bytes, or one string-end result carrying the error
//           code; out_last_of_run marks the final result of an input byte.
//   An input byte causes 0 to 4 results. The first result
//   shows in the cycle after the input transaction. Input is taken every
//   cycle as long as each byte gives at most one result and the receiver
//   is ready; a byte that gives several results holds the result register
//   until all have left, and the next input transaction is taken in the
//   cycle its last result leaves. Escape bytes give no result, but like any
//   byte they wait while the result register still holds results. The
//   escape decoder is a single pass of logic into the result register, so
//   the output port is the only thing that sets the pace.
//   Reset (rst_n low, synchronous) drops pending results and returns the
//   decoder to plain string content. A stalled receiver holds the current
//   result steady and stops input once the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_string_end,
  output logic [2:0]      out_error_code,
  output logic            out_last_of_run
);

  jsu_bundle_t bundle;
  logic        accept;

  assign accept = in_valid && in_ready;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .accept  (accept),
    .bundle  (bundle)
  );

  jsu_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .bundle          (bundle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_string_end  (out_string_end),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// File: hdl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks of the unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker import jsu_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_has_byte,
  input wire logic       out_string_end,
  input wire logic [2:0] out_error_code,
  input wire logic       out_last_of_run
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_has_byte) && $stable(out_string_end) && $stable(out_error_code))
    else $error("result changed while stalled");

  // input only stalls behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a result without data is always a string end
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_string_end && out_byte == 8'h00)
    else $error("empty result that is not a string end");

  // an error result ends the string and is not marked last
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |->
      out_string_end && !out_has_byte && !out_last_of_run)
    else $error("malformed error result");

  // data results carry no end and no error
  a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> !out_string_end && out_error_code == ERR_NONE)
    else $error("data result flagged as end or error");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);

`default_nettype wire
